// ===== src/lpsrs_pkg.sv =====
// Shared types, constants and the sensor byte packing for the light and
// proximity sensor register slave. No dependencies.
package lpsrs_pkg;

  localparam int unsigned LAST_REGISTER_DEF = 64;

  localparam int unsigned MODE_W     = 2;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned ALS_W      = 16;
  localparam int unsigned PROX_W     = 10;
  localparam int unsigned IR_W       = 10;

  typedef enum logic [MODE_W-1:0] {
    MODE_START = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_READ  = 2'd2,
    MODE_OTHER = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALS  = 2'd0,
    CFG_PROX = 2'd1,
    CFG_IR   = 2'd2
  } cfg_idx_t;

  localparam logic [BYTE_W-1:0] REG_SYSTEM      = 8'h00;
  localparam logic [BYTE_W-1:0] REG_IR_LO       = 8'h0A;
  localparam logic [BYTE_W-1:0] REG_IR_HI       = 8'h0B;
  localparam logic [BYTE_W-1:0] REG_ALS_LO      = 8'h0C;
  localparam logic [BYTE_W-1:0] REG_ALS_HI      = 8'h0D;
  localparam logic [BYTE_W-1:0] REG_PS_LO       = 8'h0E;
  localparam logic [BYTE_W-1:0] REG_PS_HI       = 8'h0F;
  localparam logic [BYTE_W-1:0] SOFT_RESET_CODE = 8'h04;
  localparam logic [BYTE_W-1:0] OUT_OF_MAP_BYTE = 8'hFF;

  localparam logic [ALS_W-1:0]  ALS_RESET  = 16'd200;
  localparam logic [PROX_W-1:0] PROX_RESET = 10'd100;
  localparam logic [IR_W-1:0]   IR_RESET   = 10'd50;

  typedef struct packed {
    logic [ALS_W-1:0]  als;
    logic [PROX_W-1:0] prox;
    logic [IR_W-1:0]   ir;
  } sensor_cfg_t;

  // Byte seen at one of the sensor data registers right after a repack.
  function automatic logic [BYTE_W-1:0] pack_sensor(input logic [BYTE_W-1:0] addr,
                                                    input sensor_cfg_t    cfg,
                                                    input logic           near);
    logic [BYTE_W-1:0] b;
    b = '0;
    unique case (addr)
      REG_IR_LO:  b = {6'b0, cfg.ir[1:0]};
      REG_IR_HI:  b = cfg.ir[9:2];
      REG_ALS_LO: b = cfg.als[7:0];
      REG_ALS_HI: b = cfg.als[15:8];
      REG_PS_LO:  b = {near, 3'b0, cfg.prox[3:0]};
      REG_PS_HI:  b = {near, 1'b0, cfg.prox[9:4]};
      default:    b = '0;
    endcase
    return b;
  endfunction

endpackage

// ===== src/lpsrs_in_if.sv =====
// Input channel of the sensor register slave: one bus event per beat.
// Depends on lpsrs_pkg.
interface lpsrs_in_if;
  logic                             valid;
  logic                             ready;
  logic [lpsrs_pkg::MODE_W-1:0]     mode;
  logic [lpsrs_pkg::BYTE_W-1:0]     bus_byte;

  modport source (output valid, output mode, output bus_byte, input ready);
  modport sink   (input valid, input mode, input bus_byte, output ready);
endinterface

// ===== src/lpsrs_out_if.sv =====
// Result channel of the sensor register slave: one read byte per beat.
// Depends on lpsrs_pkg.
interface lpsrs_out_if;
  logic                         valid;
  logic                         ready;
  logic [lpsrs_pkg::BYTE_W-1:0] read_byte;

  modport source (output valid, output read_byte, input ready);
  modport sink   (input valid, input read_byte, output ready);
endinterface

// ===== src/lpsrs_cfg_if.sv =====
// Configuration write channel: register index and data per beat.
// Depends on lpsrs_pkg.
interface lpsrs_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [lpsrs_pkg::CFG_IDX_W-1:0]  index;
  logic [lpsrs_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/lpsrs_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lpsrs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 65
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/lpsrs_cfg.sv =====
// Configuration registers holding the three sensor readings.
// Depends on lpsrs_pkg and lpsrs_cfg_if.
module lpsrs_cfg (
  input  logic                   clk,
  input  logic                   rst_n,
  lpsrs_cfg_if.sink              cfg_bus,
  output lpsrs_pkg::sensor_cfg_t cfg
);

  lpsrs_pkg::sensor_cfg_t cfg_r;
  logic                   wr;

  assign cfg_bus.ready = 1'b1;
  assign wr            = cfg_bus.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.als  <= lpsrs_pkg::ALS_RESET;
      cfg_r.prox <= lpsrs_pkg::PROX_RESET;
      cfg_r.ir   <= lpsrs_pkg::IR_RESET;
    end else if (wr) begin
      // Indices beyond the list are dropped.
      if (cfg_bus.index == lpsrs_pkg::CFG_ALS) begin
        cfg_r.als <= cfg_bus.data[lpsrs_pkg::ALS_W-1:0];
      end
      if (cfg_bus.index == lpsrs_pkg::CFG_PROX) begin
        cfg_r.prox <= cfg_bus.data[lpsrs_pkg::PROX_W-1:0];
      end
      if (cfg_bus.index == lpsrs_pkg::CFG_IR) begin
        cfg_r.ir <= cfg_bus.data[lpsrs_pkg::IR_W-1:0];
      end
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== src/lpsrs_core.sv =====
// Pointer control, register map and result register of the sensor slave.
// Depends on lpsrs_pkg, lpsrs_in_if, lpsrs_out_if and lpsrs_ram.
module lpsrs_core #(
  parameter int unsigned LAST_REGISTER = lpsrs_pkg::LAST_REGISTER_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  lpsrs_pkg::sensor_cfg_t cfg,
  lpsrs_in_if.sink               in_bus,
  lpsrs_out_if.source            out_bus
);

  localparam int unsigned DEPTH = LAST_REGISTER + 1;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam logic [lpsrs_pkg::BYTE_W-1:0] LAST_B = lpsrs_pkg::BYTE_W'(LAST_REGISTER);

  logic [lpsrs_pkg::BYTE_W-1:0] ptr_r, ptr_nxt;
  logic                         await_r, await_nxt;
  logic [lpsrs_pkg::PROX_W-1:0] prev_r, prev_nxt;
  logic [DEPTH-1:0]             vld_r, vld_nxt;

  logic                         s1_valid_r, s1_valid_nxt;
  logic                         s1_ram_r, s1_ram_nxt;
  logic                         s1_hit_r, s1_hit_nxt;
  logic [lpsrs_pkg::BYTE_W-1:0] s1_byte_r, s1_byte_nxt;

  logic                         acc;
  logic                         in_map;
  logic                         is_sensor;
  logic [AW-1:0]                addr;
  logic                         ram_we;
  logic                         ram_re;
  logic [lpsrs_pkg::BYTE_W-1:0] ram_rdata;
  logic                         near;
  lpsrs_pkg::mode_t             mode;

  assign mode      = lpsrs_pkg::mode_t'(in_bus.mode);
  assign in_bus.ready = !s1_valid_r || out_bus.ready;
  assign acc       = in_bus.valid && in_bus.ready;
  assign in_map    = ptr_r <= LAST_B;
  assign is_sensor = (ptr_r >= lpsrs_pkg::REG_IR_LO) && (ptr_r <= lpsrs_pkg::REG_PS_HI);
  assign addr      = ptr_r[AW-1:0];
  assign near      = prev_r > cfg.prox;

  always_comb begin
    ptr_nxt      = ptr_r;
    await_nxt    = await_r;
    prev_nxt     = prev_r;
    vld_nxt      = vld_r;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    s1_valid_nxt = s1_valid_r && !out_bus.ready;
    s1_ram_nxt   = s1_ram_r;
    s1_hit_nxt   = s1_hit_r;
    s1_byte_nxt  = s1_byte_r;
    if (acc) begin
      unique case (mode)
        lpsrs_pkg::MODE_START: begin
          await_nxt = 1'b1;
        end
        lpsrs_pkg::MODE_WRITE: begin
          if (await_r) begin
            ptr_nxt   = in_bus.bus_byte;
            await_nxt = 1'b0;
          end else begin
            ptr_nxt = ptr_r + 8'd1;
            if (in_map) begin
              ram_we        = 1'b1;
              vld_nxt[addr] = 1'b1;
            end
            // Soft reset empties the map; the pointer ends at one.
            if (ptr_r == lpsrs_pkg::REG_SYSTEM &&
                in_bus.bus_byte == lpsrs_pkg::SOFT_RESET_CODE) begin
              vld_nxt   = '0;
              await_nxt = 1'b1;
              prev_nxt  = cfg.prox;
            end
          end
        end
        lpsrs_pkg::MODE_READ: begin
          ptr_nxt      = ptr_r + 8'd1;
          s1_valid_nxt = 1'b1;
          s1_ram_nxt   = 1'b0;
          s1_hit_nxt   = 1'b0;
          if (!in_map) begin
            s1_byte_nxt = lpsrs_pkg::OUT_OF_MAP_BYTE;
          end else if (is_sensor) begin
            // Sensor registers always show a fresh repack.
            s1_byte_nxt = lpsrs_pkg::pack_sensor(ptr_r, cfg, near);
            prev_nxt    = cfg.prox;
          end else begin
            ram_re     = 1'b1;
            s1_ram_nxt = 1'b1;
            s1_hit_nxt = vld_r[addr];
          end
        end
        lpsrs_pkg::MODE_OTHER: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r      <= '0;
      await_r    <= 1'b1;
      prev_r     <= lpsrs_pkg::PROX_RESET;
      vld_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      ptr_r      <= ptr_nxt;
      await_r    <= await_nxt;
      prev_r     <= prev_nxt;
      vld_r      <= vld_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
    s1_ram_r  <= s1_ram_nxt;
    s1_hit_r  <= s1_hit_nxt;
    s1_byte_r <= s1_byte_nxt;
  end

  lpsrs_ram #(
    .WIDTH (lpsrs_pkg::BYTE_W),
    .DEPTH (DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata (in_bus.bus_byte),
    .re    (ram_re),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  // The RAM only reloads on an accepted read, so its data holds under stall.
  assign out_bus.valid     = s1_valid_r;
  assign out_bus.read_byte = s1_ram_r ? (s1_hit_r ? ram_rdata : '0) : s1_byte_r;

endmodule

// ===== src/light_proximity_sensor_register_slave_unit.sv =====
// Top level of the light and proximity sensor register slave.
// Depends on lpsrs_pkg, the channel interfaces, lpsrs_cfg and lpsrs_core.
//
// Bus event beats are accepted at one beat per cycle, the input side stalling
// only while a read byte waits and the sink is not ready; a read beat shows
// its byte on the result channel in the following cycle, from a result
// register or straight from the register-map RAM's registered read port.
// Sensor registers 0x0A to 0x0F are packed live from the configuration
// registers, so the map needs no clearing pass after reset or soft reset:
// per-entry valid bits make an unwritten entry read as zero.
module light_proximity_sensor_register_slave_unit #(
  parameter int unsigned LAST_REGISTER = lpsrs_pkg::LAST_REGISTER_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  lpsrs_in_if.sink    in_bus,
  lpsrs_out_if.source out_bus,
  lpsrs_cfg_if.sink   cfg_bus
);

  lpsrs_pkg::sensor_cfg_t cfg;

  lpsrs_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_bus (cfg_bus),
    .cfg     (cfg)
  );

  lpsrs_core #(
    .LAST_REGISTER (LAST_REGISTER)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

endmodule

// ===== src/lpsrs_checker.sv =====
// Port-level checks for the sensor register slave, bound to the top level.
// Depends on lpsrs_pkg and light_proximity_sensor_register_slave_unit.
module lpsrs_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic [lpsrs_pkg::MODE_W-1:0]     in_mode,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic                             cfg_ready
);

  logic in_acc;
  logic rd_acc;

  assign in_acc = in_valid && in_ready;
  assign rd_acc = in_acc && (in_mode == lpsrs_pkg::MODE_READ);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_read_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    rd_acc |=> out_valid)
    else $error("accepted read produced no result");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !rd_acc && (!out_valid || out_ready) |=> !out_valid)
    else $error("result without a read");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("configuration port not ready");

endmodule

bind light_proximity_sensor_register_slave_unit lpsrs_checker u_lpsrs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_bus.valid),
  .in_ready  (in_bus.ready),
  .in_mode   (in_bus.mode),
  .out_valid (out_bus.valid),
  .out_ready (out_bus.ready),
  .cfg_ready (cfg_bus.ready)
);
